>>> rtl/core/fabs_pkg.sv
`timescale 1ns / 1ps

package fabs_pkg;

  // Port widths
  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_GROUNDED = 2'd0,
    MODE_OUTSIDE  = 2'd1,
    MODE_APPROACH = 2'd2,
    MODE_NORMAL   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CFG_FORCE_ENABLE  = 3'd0,
    CFG_AIRSPEED_GAIN = 3'd1,
    CFG_WARN_TIME_MS  = 3'd2,
    CFG_SPEED_HIGH    = 3'd3,
    CFG_SPEED_MID     = 3'd4,
    CFG_TONE_MS       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        force_enable;
    logic [15:0] airspeed_gain;
    logic [15:0] warn_time_ms;
    logic [11:0] speed_high;
    logic [11:0] speed_mid;
    logic [9:0]  tone_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [16:0] reach_time;
    logic        inside_area;
    logic        took_off;
    logic [15:0] altitude;
    logic [11:0] airspeed;
  } sample_t;

  typedef struct packed {
    mode_e       mode;
    logic [10:0] pitch;
    logic [9:0]  off_time;
    logic [31:0] now_ms;
  } feat_t;

  typedef struct packed {
    logic [1:0]  flight_mode;
    logic [10:0] pitch_hz;
    logic        sounding;
  } result_t;

  // Register reset values
  localparam logic        RST_FORCE_ENABLE  = 1'b0;
  localparam logic [15:0] RST_AIRSPEED_GAIN = 16'd256;
  localparam logic [15:0] RST_WARN_TIME_MS  = 16'd6000;
  localparam logic [11:0] RST_SPEED_HIGH    = 12'd1080;
  localparam logic [11:0] RST_SPEED_MID     = 12'd950;
  localparam logic [9:0]  RST_TONE_MS       = 10'd300;

  // Tone frequencies
  localparam logic [10:0] PITCH_LOW  = 11'd440;
  localparam logic [10:0] PITCH_MID  = 11'd880;
  localparam logic [10:0] PITCH_HIGH = 11'd1320;

  // Beep period map
  localparam logic [14:0] ALT_HIGH_MM    = 15'd1500;
  localparam logic [9:0]  PERIOD_HIGH_MS = 10'd900;
  localparam logic [9:0]  PERIOD_BASE_MS = 10'd125;
  localparam logic [9:0]  PERIOD_NEG_MS  = 10'd100;
  // 575/1000 = 23/40: multiply by 23, shift by 3, then divide by 5.
  localparam logic [15:0] SLOPE_NUM  = 16'd23;
  localparam logic [26:0] RECIP_FIVE = 27'd13108;

endpackage

>>> rtl/core/flight_audio_beep_sequencer_top.sv
`timescale 1ns / 1ps
// Pipeline: an accepted beat moves through the input, feature and result registers.
// Throughput: one sample per cycle unless the output stalls; each register holds one
// sample and they advance independently, so bubbles close up while the output stalls.
// Reset: rst_ni clears all valid flags and the tone state and loads the register
// defaults (gain 1.0, warn 6000 ms, speeds 1080/950, tone 300 ms, force off).

module flight_audio_beep_sequencer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // airspeed[11:0], altitude[27:12], took_off[28], inside_area[29],
  // reach_time[46:30], now_ms[78:47], zero[79]
  input  logic [fabs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sounding[0], pitch_hz[11:1], flight_mode[13:12], zero[15:14]
  output logic [fabs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [fabs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fabs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  fabs_pkg::cfg_t    cfg_q;
  logic              in_v_q;
  fabs_pkg::sample_t in_q;
  fabs_pkg::sample_t in_d;
  logic              feat_ready;
  logic              feat_valid;
  fabs_pkg::feat_t   feat;
  logic              tone_ready;
  fabs_pkg::result_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_enable  <= fabs_pkg::RST_FORCE_ENABLE;
      cfg_q.airspeed_gain <= fabs_pkg::RST_AIRSPEED_GAIN;
      cfg_q.warn_time_ms  <= fabs_pkg::RST_WARN_TIME_MS;
      cfg_q.speed_high    <= fabs_pkg::RST_SPEED_HIGH;
      cfg_q.speed_mid     <= fabs_pkg::RST_SPEED_MID;
      cfg_q.tone_ms       <= fabs_pkg::RST_TONE_MS;
    end else if (cfg_we_i) begin
      case (fabs_pkg::cfg_idx_e'(cfg_idx_i))
        fabs_pkg::CFG_FORCE_ENABLE:  cfg_q.force_enable  <= cfg_data_i[0];
        fabs_pkg::CFG_AIRSPEED_GAIN: cfg_q.airspeed_gain <= cfg_data_i;
        fabs_pkg::CFG_WARN_TIME_MS:  cfg_q.warn_time_ms  <= cfg_data_i;
        fabs_pkg::CFG_SPEED_HIGH:    cfg_q.speed_high    <= cfg_data_i[11:0];
        fabs_pkg::CFG_SPEED_MID:     cfg_q.speed_mid     <= cfg_data_i[11:0];
        fabs_pkg::CFG_TONE_MS:       cfg_q.tone_ms       <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  assign in_d.airspeed    = s_axis_tdata[11:0];
  assign in_d.altitude    = s_axis_tdata[27:12];
  assign in_d.took_off    = s_axis_tdata[28];
  assign in_d.inside_area = s_axis_tdata[29];
  assign in_d.reach_time  = s_axis_tdata[46:30];
  assign in_d.now_ms      = s_axis_tdata[78:47];

  assign s_axis_tready = !in_v_q || feat_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  fabs_feature u_feature (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_v_q),
    .in_i         (in_q),
    .cfg_i        (cfg_q),
    .dn_ready_i   (tone_ready),
    .up_ready_o   (feat_ready),
    .feat_valid_o (feat_valid),
    .feat_o       (feat)
  );

  fabs_tone u_tone (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .feat_valid_i (feat_valid),
    .feat_i       (feat),
    .tone_ms_i    (cfg_q.tone_ms),
    .dn_ready_i   (m_axis_tready),
    .up_ready_o   (tone_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_o        (result)
  );

  assign m_axis_tdata = {2'b00, result.flight_mode, result.pitch_hz, result.sounding};

endmodule

>>> rtl/core/fabs_feature.sv
`timescale 1ns / 1ps

module fabs_feature (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fabs_pkg::sample_t in_i,
  input  fabs_pkg::cfg_t    cfg_i,
  input  logic              dn_ready_i,
  output logic              up_ready_o,
  output logic              feat_valid_o,
  output fabs_pkg::feat_t   feat_o
);

  logic            feat_v_q;
  fabs_pkg::feat_t feat_q;
  fabs_pkg::feat_t feat_d;

  logic [27:0] adj_speed;
  logic        rt_pos;
  logic        near_edge;
  logic        alt_neg;
  logic        alt_high;
  logic [15:0] alt_x23;
  logic [12:0] alt_div8;
  logic [26:0] div5_prod;
  logic [9:0]  period;

  assign adj_speed = 28'(in_i.airspeed) * 28'(cfg_i.airspeed_gain);

  assign rt_pos    = !in_i.reach_time[16] && (in_i.reach_time != '0);
  assign near_edge = rt_pos && (in_i.reach_time[15:0] < cfg_i.warn_time_ms);

  assign alt_neg   = in_i.altitude[15];
  assign alt_high  = !alt_neg && (in_i.altitude[14:0] >= fabs_pkg::ALT_HIGH_MM);
  // Only used when 0 <= altitude < 1500, so eleven bits cover it.
  assign alt_x23   = 16'(in_i.altitude[10:0]) * fabs_pkg::SLOPE_NUM;
  assign alt_div8  = alt_x23[15:3];
  assign div5_prod = 27'(alt_div8) * fabs_pkg::RECIP_FIVE;

  always_comb begin
    if (alt_neg) begin
      period = fabs_pkg::PERIOD_NEG_MS;
    end else if (alt_high) begin
      period = fabs_pkg::PERIOD_HIGH_MS;
    end else begin
      period = fabs_pkg::PERIOD_BASE_MS + div5_prod[25:16];
    end
  end

  always_comb begin
    feat_d.now_ms = in_i.now_ms;

    if (!in_i.took_off && !cfg_i.force_enable) begin
      feat_d.mode = fabs_pkg::MODE_GROUNDED;
    end else if (!in_i.inside_area) begin
      feat_d.mode = fabs_pkg::MODE_OUTSIDE;
    end else if (near_edge) begin
      feat_d.mode = fabs_pkg::MODE_APPROACH;
    end else begin
      feat_d.mode = fabs_pkg::MODE_NORMAL;
    end

    if (adj_speed >= 28'({cfg_i.speed_high, 8'h00})) begin
      feat_d.pitch = fabs_pkg::PITCH_HIGH;
    end else if (adj_speed >= 28'({cfg_i.speed_mid, 8'h00})) begin
      feat_d.pitch = fabs_pkg::PITCH_MID;
    end else begin
      feat_d.pitch = fabs_pkg::PITCH_LOW;
    end

    if (period > cfg_i.tone_ms) begin
      feat_d.off_time = period - cfg_i.tone_ms;
    end else begin
      feat_d.off_time = '0;
    end
  end

  assign up_ready_o = !feat_v_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_v_q <= 1'b0;
    end else if (up_ready_o) begin
      feat_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && in_valid_i) begin
      feat_q <= feat_d;
    end
  end

  assign feat_valid_o = feat_v_q;
  assign feat_o       = feat_q;

endmodule

>>> rtl/core/fabs_tone.sv
`timescale 1ns / 1ps

module fabs_tone (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              feat_valid_i,
  input  fabs_pkg::feat_t   feat_i,
  input  logic [9:0]        tone_ms_i,
  input  logic              dn_ready_i,
  output logic              up_ready_o,
  output logic              out_valid_o,
  output fabs_pkg::result_t out_o
);

  // Sequencer state, advanced once per sample entering the result register.
  logic            prev_vld_q, prev_vld_d;
  fabs_pkg::mode_e prev_mode_q, prev_mode_d;
  logic            phase_on_q, phase_on_d;
  logic [31:0]     phase_start_q, phase_start_d;
  logic            tone_on_q, tone_on_d;
  logic [10:0]     tone_freq_q, tone_freq_d;

  logic              out_v_q;
  fabs_pkg::result_t out_q, out_d;
  logic              fire;
  logic              mode_change;
  logic [31:0]       elapsed;

  assign up_ready_o = !out_v_q || dn_ready_i;
  assign fire       = feat_valid_i && up_ready_o;
  assign mode_change = !prev_vld_q || (feat_i.mode != prev_mode_q);

  always_comb begin
    prev_vld_d    = 1'b1;
    prev_mode_d   = feat_i.mode;
    phase_on_d    = phase_on_q;
    phase_start_d = phase_start_q;
    tone_on_d     = tone_on_q;
    tone_freq_d   = tone_freq_q;

    if (mode_change) begin
      phase_on_d    = 1'b0;
      phase_start_d = feat_i.now_ms;
      tone_on_d     = 1'b0;
      case (feat_i.mode)
        fabs_pkg::MODE_OUTSIDE: begin
          tone_on_d   = 1'b1;
          tone_freq_d = fabs_pkg::PITCH_LOW;
        end
        fabs_pkg::MODE_APPROACH: begin
          tone_on_d   = 1'b1;
          tone_freq_d = fabs_pkg::PITCH_MID;
        end
        default: begin
        end
      endcase
    end

    // On a mode change the phase restarts now, so elapsed comes out as zero.
    elapsed = feat_i.now_ms - phase_start_d;

    if (feat_i.mode == fabs_pkg::MODE_NORMAL) begin
      if (!phase_on_d && (elapsed > 32'(feat_i.off_time))) begin
        tone_on_d     = 1'b1;
        tone_freq_d   = feat_i.pitch;
        phase_start_d = feat_i.now_ms;
        phase_on_d    = 1'b1;
      end else if (phase_on_d && (elapsed > 32'(tone_ms_i))) begin
        tone_on_d     = 1'b0;
        phase_start_d = feat_i.now_ms;
        phase_on_d    = 1'b0;
      end
    end

    out_d.sounding    = tone_on_d;
    out_d.pitch_hz    = tone_on_d ? tone_freq_d : '0;
    out_d.flight_mode = feat_i.mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vld_q    <= 1'b0;
      prev_mode_q   <= fabs_pkg::MODE_GROUNDED;
      phase_on_q    <= 1'b0;
      phase_start_q <= '0;
      tone_on_q     <= 1'b0;
      tone_freq_q   <= '0;
    end else if (fire) begin
      prev_vld_q    <= prev_vld_d;
      prev_mode_q   <= prev_mode_d;
      phase_on_q    <= phase_on_d;
      phase_start_q <= phase_start_d;
      tone_on_q     <= tone_on_d;
      tone_freq_q   <= tone_freq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (up_ready_o) begin
      out_v_q <= feat_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  a_silent_no_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.sounding |-> out_q.pitch_hz == '0)
    else $error("silent beat carries a pitch");

  a_grounded_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.flight_mode == fabs_pkg::MODE_GROUNDED) |-> !out_q.sounding)
    else $error("tone on while grounded");

  a_outside_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.flight_mode == fabs_pkg::MODE_OUTSIDE)
    |-> out_q.sounding && (out_q.pitch_hz == fabs_pkg::PITCH_LOW))
    else $error("outside-area alarm not at low pitch");

  a_approach_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (out_q.flight_mode == fabs_pkg::MODE_APPROACH)
    |-> out_q.sounding && (out_q.pitch_hz == fabs_pkg::PITCH_MID))
    else $error("boundary alarm not at mid pitch");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !dn_ready_i |=> out_v_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

>>> tb/sv/tb_flight_audio_beep_sequencer_top.sv
`timescale 1ns / 1ps

module tb_flight_audio_beep_sequencer_top;

  // Indexes past the last register; writes to them must leave every register alone.
  localparam logic [2:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [2:0] {
    RUN_NORMAL,
    RUN_APPROACH,
    RUN_OUTSIDE,
    RUN_GROUNDED,
    RUN_NOISE
  } run_kind_e;

  class beep_scoreboard;
    logic              force_en;
    logic [15:0]       gain_q88;
    logic [15:0]       warn_ms;
    logic [11:0]       spd_high;
    logic [11:0]       spd_mid;
    logic [9:0]        beep_ms;
    logic [2:0]        mode_seen;
    logic              phase_on;
    logic [31:0]       phase_t0;
    logic              tone_on;
    logic [10:0]       tone_hz;
    fabs_pkg::result_t expected_q[$];
    int unsigned       mismatches;

    function new();
      force_en   = fabs_pkg::RST_FORCE_ENABLE;
      gain_q88   = fabs_pkg::RST_AIRSPEED_GAIN;
      warn_ms    = fabs_pkg::RST_WARN_TIME_MS;
      spd_high   = fabs_pkg::RST_SPEED_HIGH;
      spd_mid    = fabs_pkg::RST_SPEED_MID;
      beep_ms    = fabs_pkg::RST_TONE_MS;
      // One past the last mode, so the first sample always counts as a mode change.
      mode_seen  = 3'd4;
      phase_on   = 1'b0;
      phase_t0   = '0;
      tone_on    = 1'b0;
      tone_hz    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        fabs_pkg::CFG_FORCE_ENABLE:  force_en = data[0];
        fabs_pkg::CFG_AIRSPEED_GAIN: gain_q88 = data;
        fabs_pkg::CFG_WARN_TIME_MS:  warn_ms  = data;
        fabs_pkg::CFG_SPEED_HIGH:    spd_high = data[11:0];
        fabs_pkg::CFG_SPEED_MID:     spd_mid  = data[11:0];
        fabs_pkg::CFG_TONE_MS:       beep_ms  = data[9:0];
        default: ;
      endcase
    endfunction

    function void note_sample(fabs_pkg::sample_t smp);
      int                alt;
      int                rt;
      fabs_pkg::mode_e   mode;
      logic [27:0]       adj;
      logic [10:0]       pitch;
      logic [31:0]       period;
      logic [31:0]       off_ms;
      logic [31:0]       elapsed;
      fabs_pkg::result_t res;
      alt = $signed(smp.altitude);
      rt  = $signed(smp.reach_time);
      if (!smp.took_off && !force_en) begin
        mode = fabs_pkg::MODE_GROUNDED;
      end else if (!smp.inside_area) begin
        mode = fabs_pkg::MODE_OUTSIDE;
      end else if (rt > 0 && rt < int'(warn_ms)) begin
        mode = fabs_pkg::MODE_APPROACH;
      end else begin
        mode = fabs_pkg::MODE_NORMAL;
      end

      if ({1'b0, mode} != mode_seen) begin
        tone_on  = 1'b0;
        phase_on = 1'b0;
        phase_t0 = smp.now_ms;
        if (mode == fabs_pkg::MODE_OUTSIDE) begin
          tone_on = 1'b1;
          tone_hz = fabs_pkg::PITCH_LOW;
        end else if (mode == fabs_pkg::MODE_APPROACH) begin
          tone_on = 1'b1;
          tone_hz = fabs_pkg::PITCH_MID;
        end
        mode_seen = {1'b0, mode};
      end

      if (mode == fabs_pkg::MODE_NORMAL) begin
        // Thresholds are in cm/s while the product carries the Q8.8 gain.
        adj = smp.airspeed * gain_q88;
        if (adj >= {spd_high, 8'd0}) begin
          pitch = fabs_pkg::PITCH_HIGH;
        end else if (adj >= {spd_mid, 8'd0}) begin
          pitch = fabs_pkg::PITCH_MID;
        end else begin
          pitch = fabs_pkg::PITCH_LOW;
        end
        if (alt >= 1500) begin
          period = 900;
        end else if (alt >= 0) begin
          period = 125 + (alt * 575) / 1000;
        end else begin
          period = 100;
        end
        off_ms  = (period > beep_ms) ? period - beep_ms : 32'd0;
        elapsed = smp.now_ms - phase_t0;
        if (!phase_on && elapsed > off_ms) begin
          tone_on  = 1'b1;
          tone_hz  = pitch;
          phase_t0 = smp.now_ms;
          phase_on = 1'b1;
        end else if (phase_on && elapsed > beep_ms) begin
          tone_on  = 1'b0;
          phase_t0 = smp.now_ms;
          phase_on = 1'b0;
        end
      end

      res.sounding    = tone_on;
      res.pitch_hz    = tone_on ? tone_hz : 11'd0;
      res.flight_mode = mode;
      expected_q.push_back(res);
    endfunction

    function void check_result(fabs_pkg::result_t got);
      fabs_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat %h arrived with nothing expected", $time, got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.sounding !== want.sounding) begin
          $display("%0t: sounding expected %0d actual %0d", $time, want.sounding,
                   got.sounding);
          mismatches++;
        end
        if (got.pitch_hz !== want.pitch_hz) begin
          $display("%0t: pitch_hz expected %0d actual %0d", $time, want.pitch_hz,
                   got.pitch_hz);
          mismatches++;
        end
        if (got.flight_mode !== want.flight_mode) begin
          $display("%0t: flight_mode expected %0d actual %0d", $time, want.flight_mode,
                   got.flight_mode);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic [fabs_pkg::S_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [fabs_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_we_i;
  logic [fabs_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fabs_pkg::CFG_DATA_W-1:0] cfg_data_i;

  beep_scoreboard sb;
  int             burst_left;
  run_kind_e      run_kind;
  int             run_left;
  logic [31:0]    clock_ms;

  flight_audio_beep_sequencer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_sample(fabs_pkg::sample_t smp);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tdata  <= {1'b0, smp};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(smp);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [11:0] spd, logic [15:0] alt, logic up, logic in_area,
                             logic [16:0] rt, logic [31:0] now);
    fabs_pkg::sample_t smp;
    smp.airspeed    = spd;
    smp.altitude    = alt;
    smp.took_off    = up;
    smp.inside_area = in_area;
    smp.reach_time  = rt;
    smp.now_ms      = now;
    send_sample(smp);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Samples come in runs of one kind so that normal flight lasts long enough for the
  // beep timer to cycle; time mostly moves forward in small steps.
  function automatic fabs_pkg::sample_t make_sample();
    fabs_pkg::sample_t smp;
    int                pick;
    if (run_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        run_kind = RUN_NORMAL;
        run_left = $urandom_range(8, 40);
      end else if (pick < 70) begin
        run_kind = RUN_APPROACH;
        run_left = $urandom_range(1, 6);
      end else if (pick < 82) begin
        run_kind = RUN_OUTSIDE;
        run_left = $urandom_range(1, 6);
      end else if (pick < 92) begin
        run_kind = RUN_GROUNDED;
        run_left = $urandom_range(1, 6);
      end else begin
        run_kind = RUN_NOISE;
        run_left = $urandom_range(1, 3);
      end
    end
    run_left--;

    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      clock_ms += $urandom_range(0, 400);
    end else if (pick < 95) begin
      clock_ms += $urandom_range(0, 3000);
    end else begin
      clock_ms += $urandom();
    end

    smp.airspeed = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      smp.altitude = $urandom_range(0, 1600);
    end else if (pick < 80) begin
      smp.altitude = -$urandom_range(1, 32768);
    end else begin
      smp.altitude = $urandom();
    end
    smp.took_off    = sb.force_en ? $urandom_range(0, 1) : 1'b1;
    smp.inside_area = 1'b1;
    smp.reach_time  = $urandom();
    smp.now_ms      = clock_ms;

    case (run_kind)
      RUN_NORMAL: begin
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          smp.reach_time = '0;
        end else if (pick == 1) begin
          smp.reach_time = -$urandom_range(1, 65536);
        end else begin
          smp.reach_time = $urandom_range(sb.warn_ms, 65535);
        end
      end
      RUN_APPROACH: begin
        if (sb.warn_ms > 1) smp.reach_time = $urandom_range(1, sb.warn_ms - 1);
      end
      RUN_OUTSIDE: begin
        smp.inside_area = 1'b0;
      end
      RUN_GROUNDED: begin
        smp.took_off    = 1'b0;
        smp.inside_area = $urandom_range(0, 1);
      end
      default: begin
        smp.took_off    = $urandom_range(0, 1);
        smp.inside_area = $urandom_range(0, 1);
        smp.now_ms      = $urandom();
      end
    endcase
    return smp;
  endfunction

  initial begin
    logic        fe;
    logic [15:0] g;
    logic [15:0] w;
    logic [11:0] sh;
    logic [11:0] sm;
    logic [9:0]  tm;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    sb            = new();
    burst_left    = 0;
    run_left      = 0;
    run_kind      = RUN_NORMAL;
    clock_ms      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_cfg(CFG_IDX_SPARE_LO, 16'hFFFF);
    write_cfg(CFG_IDX_SPARE_HI, 16'hFFFF);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);

    // Directed samples under the reset settings.
    send_fields(12'd0, -16'sd32768, 1'b0, 1'b0, 17'd0, 32'd0);
    send_fields(12'd4095, 16'd32767, 1'b0, 1'b1, 17'd65535, 32'd10);
    send_fields(12'd0, 16'd0, 1'b1, 1'b0, 17'd0, 32'd20);
    send_fields(12'd0, 16'd0, 1'b1, 1'b1, 17'd1, 32'd30);
    send_fields(12'd0, 16'd0, 1'b1, 1'b1, 17'd5999, 32'd40);
    // Reach time equal to the warning time is normal flight.
    send_fields(12'd949, 16'd1499, 1'b1, 1'b1, 17'd6000, 32'd50);
    send_fields(12'd950, 16'd1499, 1'b1, 1'b1, 17'd0, 32'd800);
    send_fields(12'd1080, 16'd1500, 1'b1, 1'b1, -17'sd1, 32'd1000);
    send_fields(12'd4095, -16'sd1, 1'b1, 1'b1, -17'sd65536, 32'd1101);
    send_fields(12'd4095, -16'sd32768, 1'b1, 1'b1, -17'sd65536, 32'd1102);
    send_fields(12'd0, 16'd32767, 1'b1, 1'b1, 17'd65535, 32'd1500);
    // The beep timer has to survive the timestamp wrapping.
    send_fields(12'd1080, 16'd0, 1'b1, 1'b1, 17'd0, 32'hFFFF_FF00);
    send_fields(12'd1080, 16'd0, 1'b1, 1'b1, 17'd0, 32'h0000_0100);
    send_fields(12'd1079, 16'd0, 1'b1, 1'b1, 17'd0, 32'h0000_0300);
    send_fields(12'd100, 16'd700, 1'b0, 1'b1, 17'd100, 32'h0000_0400);
    send_fields(12'd4095, 16'd32767, 1'b1, 1'b0, 17'd65535, 32'hFFFF_FFFF);
    send_fields(12'd0, 16'd0, 1'b1, 1'b1, 17'd3000, 32'h0000_0001);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          fe = 1'b0; g = '0; w = '0; sh = '0; sm = '0; tm = '0;
        end
        1: begin
          fe = 1'b1; g = '1; w = '1; sh = '1; sm = '1; tm = '1;
        end
        default: begin
          fe = $urandom_range(0, 1);
          g  = $urandom_range(64, 1024);
          w  = $urandom();
          sh = $urandom();
          sm = $urandom_range(0, sh);
          tm = $urandom();
        end
      endcase
      write_cfg(fabs_pkg::CFG_FORCE_ENABLE, {15'd0, fe});
      write_cfg(fabs_pkg::CFG_AIRSPEED_GAIN, g);
      write_cfg(fabs_pkg::CFG_WARN_TIME_MS, w);
      write_cfg(fabs_pkg::CFG_SPEED_HIGH, {4'd0, sh});
      write_cfg(fabs_pkg::CFG_SPEED_MID, {4'd0, sm});
      write_cfg(fabs_pkg::CFG_TONE_MS, {6'd0, tm});
      cfg_we_i <= 1'b0;
      clock_ms = (ph == 2) ? 32'hFFFF_F000 : $urandom();
      run_left = 0;
      repeat (ITEMS_PER_PHASE) send_sample(make_sample());
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: the readiness style changes now and then, and long hold-offs recur so the
  // pipeline backs up into the input.
  initial begin
    int         ready_style;
    int         style_left;
    int         hold_at;
    int         hold_left;
    logic [7:0] ready_pattern;
    logic [2:0] beat_phase;
    m_axis_tready = 1'b0;
    ready_style   = 0;
    style_left    = 0;
    hold_at       = $urandom_range(150, 400);
    hold_left     = 0;
    ready_pattern = '1;
    beat_phase    = '0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      beat_phase++;
      if (style_left == 0) begin
        ready_style   = $urandom_range(0, 3);
        style_left    = $urandom_range(30, 150);
        ready_pattern = $urandom();
      end
      style_left--;
      if (hold_at == 0) begin
        hold_left = $urandom_range(40, 90);
        hold_at   = $urandom_range(300, 800);
      end
      hold_at--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ready_pattern[beat_phase];
        endcase
      end
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(fabs_pkg::result_t'(m_axis_tdata[13:0]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
